/* rtl/core/kwef_pkg.sv */
package kwef_pkg;

    // Channel and number formats
    localparam int MAX_CHANNELS = 5;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 32;
    localparam int COEF_FRAC    = 28;
    localparam int ENERGY_FRAC  = 46;
    localparam int ENERGY_BITS  = 63;
    localparam int WEIGHT_FRAC  = 16;
    localparam int WEIGHT_BITS  = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Shared multiplier: signed operands one bit wider than the widest input
    localparam int MUL_W  = ((COEF_BITS > SAMPLE_BITS) ? COEF_BITS : SAMPLE_BITS) + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Filter accumulator and the linear part of the high-pass numerator
    localparam int ACC_W   = COEF_BITS + 8;
    localparam int LIN_W   = COEF_BITS + 3;
    localparam int SHIFT_X = SAMPLE_BITS - 1;
    localparam int SHIFT_C = COEF_FRAC;

    // Squared output split into two parts for the weight multiply
    localparam int SQ_SHIFT = 2 * COEF_FRAC - ENERGY_FRAC;
    localparam int LO_BITS  = 26;
    localparam int HI_LSB   = SQ_SHIFT + LO_BITS;
    localparam int HI_BITS  = 2 * COEF_BITS - 1 - HI_LSB;
    localparam int HI_SHIFT = LO_BITS - WEIGHT_FRAC;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_UNIT     = WEIGHT_BITS'(65536);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_SURROUND = WEIGHT_BITS'(92406);

    // Per-channel weight in Q.16: surround channels get 1.41
    function automatic logic [WEIGHT_BITS-1:0] chan_weight(input logic [IDX_W-1:0] idx);
        logic [WEIGHT_BITS-1:0] w;
        if ((idx == IDX_W'(3)) || (idx == IDX_W'(4))) begin
            w = WEIGHT_SURROUND;
        end else begin
            w = WEIGHT_UNIT;
        end
        return w;
    endfunction

endpackage

/* rtl/core/kwef_mul.sv */
module kwef_mul (
    input  logic                                i_clk,
    input  logic signed [kwef_pkg::MUL_W-1:0]   i_a,
    input  logic signed [kwef_pkg::MUL_W-1:0]   i_b,
    output logic signed [kwef_pkg::PROD_W-1:0]  o_prod
);
    import kwef_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // Register the product of the selected operands
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/k_weighting_energy_filter_core.sv */
// K-weighting energy filter: two biquads per channel, weighted squared sum.
// A primed frame with n active channels gives its result once every channel has run
// the step sequence; a priming frame skips it; a flush before priming gives none.
// No new frame is taken until the last is through (o_stall is high while busy): the
// single 33x33 multiplier is used ten times per channel under the step sequencer.
// Reset (synchronous, active low) loads default coefficients and clears all history.
module k_weighting_energy_filter_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [kwef_pkg::SAMPLE_BITS-1:0] i_sample_ch0,
    input  logic signed [kwef_pkg::SAMPLE_BITS-1:0] i_sample_ch1,
    input  logic signed [kwef_pkg::SAMPLE_BITS-1:0] i_sample_ch2,
    input  logic signed [kwef_pkg::SAMPLE_BITS-1:0] i_sample_ch3,
    input  logic signed [kwef_pkg::SAMPLE_BITS-1:0] i_sample_ch4,
    input  logic                                    i_flush,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [kwef_pkg::ENERGY_BITS-1:0]        o_weighted_energy,
    input  logic                                    i_cfg_we,
    input  logic [kwef_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [kwef_pkg::COEF_BITS-1:0]          i_cfg_data
);
    import kwef_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT,
        CFG_SHELF_B0,
        CFG_SHELF_B1,
        CFG_SHELF_B2,
        CFG_SHELF_A1,
        CFG_SHELF_A2,
        CFG_HIGHPASS_A1,
        CFG_HIGHPASS_A2
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B0,
        ST_B1,
        ST_B2,
        ST_SA1,
        ST_SA2,
        ST_HA1,
        ST_HA2,
        ST_LIN,
        ST_ZCLAMP,
        ST_SQ,
        ST_WLO,
        ST_WHI,
        ST_EHI,
        ST_FINISH
    } t_state;

    localparam logic [2:0] CH_COUNT_RESET = 3'd2;
    localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = {ENERGY_BITS{1'b1}};

    // Configuration registers
    logic [2:0]                  r_channel_count;
    logic signed [COEF_BITS-1:0] r_shelf_b0, r_shelf_b1, r_shelf_b2;
    logic signed [COEF_BITS-1:0] r_shelf_a1, r_shelf_a2;
    logic signed [COEF_BITS-1:0] r_highpass_a1, r_highpass_a2;

    // Control
    t_state                r_state;
    logic                  r_primed;
    logic [IDX_W-1:0]      r_ch;
    logic                  r_ovalid;
    logic [ENERGY_BITS-1:0] r_oenergy;

    // Channel histories
    logic signed [SAMPLE_BITS-1:0] r_xh1 [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_xh2 [MAX_CHANNELS];
    logic signed [COEF_BITS-1:0]   r_yh1 [MAX_CHANNELS];
    logic signed [COEF_BITS-1:0]   r_yh2 [MAX_CHANNELS];
    logic signed [COEF_BITS-1:0]   r_zh1 [MAX_CHANNELS];
    logic signed [COEF_BITS-1:0]   r_zh2 [MAX_CHANNELS];

    // Datapath
    logic signed [SAMPLE_BITS-1:0] r_frame [MAX_CHANNELS];
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [COEF_BITS-1:0]   r_y;
    logic signed [COEF_BITS-1:0]   r_z;
    logic signed [LIN_W-1:0]       r_lin;
    logic [HI_BITS-1:0]            r_hi;
    logic [ENERGY_BITS-1:0]        r_energy;

    logic signed [SAMPLE_BITS-1:0] s_sample [MAX_CHANNELS];
    logic signed [MUL_W-1:0]       s_mul_a, s_mul_b;
    logic signed [PROD_W-1:0]      s_prod;
    logic signed [PROD_W-1:0]      s_shx, s_shc;
    logic signed [ACC_W-1:0]       s_tx, s_tc;
    logic [ENERGY_BITS-1:0]        s_part_lo, s_part_hi;
    logic [WEIGHT_BITS-1:0]        s_weight;
    logic [CNT_W-1:0]              s_n;
    logic                          s_accept;
    logic                          s_last;

    // Bring a wide sum back to the signed stage range
    function automatic logic signed [COEF_BITS-1:0] clamp(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]     hi_lim;
        logic signed [ACC_W-1:0]     lo_lim;
        logic signed [COEF_BITS-1:0] r;
        hi_lim = ACC_W'($signed({1'b0, {(COEF_BITS-1){1'b1}}}));
        lo_lim = ACC_W'($signed({1'b1, {(COEF_BITS-1){1'b0}}}));
        if (v > hi_lim) begin
            r = hi_lim[COEF_BITS-1:0];
        end else if (v < lo_lim) begin
            r = lo_lim[COEF_BITS-1:0];
        end else begin
            r = v[COEF_BITS-1:0];
        end
        return r;
    endfunction

    // Add a nonnegative term to the energy, saturating at full scale
    function automatic logic [ENERGY_BITS-1:0] sat_add(input logic [ENERGY_BITS-1:0] e,
                                                       input logic [ENERGY_BITS-1:0] t);
        logic [ENERGY_BITS:0] s;
        s = {1'b0, e} + {1'b0, t};
        return s[ENERGY_BITS] ? ENERGY_MAX : s[ENERGY_BITS-1:0];
    endfunction

    assign s_sample[0] = i_sample_ch0;
    assign s_sample[1] = i_sample_ch1;
    assign s_sample[2] = i_sample_ch2;
    assign s_sample[3] = i_sample_ch3;
    assign s_sample[4] = i_sample_ch4;

    assign s_n      = (r_channel_count > 3'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                            : CNT_W'(r_channel_count);
    assign s_accept = i_valid && (r_state == ST_IDLE);
    assign s_last   = ((CNT_W'(r_ch) + CNT_W'(1)) == s_n);
    assign s_weight = chan_weight(r_ch);

    assign o_stall           = (r_state != ST_IDLE);
    assign o_valid           = r_ovalid;
    assign o_weighted_energy = r_oenergy;

    // Scale products back to the stage format
    assign s_shx     = s_prod >>> SHIFT_X;
    assign s_shc     = s_prod >>> SHIFT_C;
    assign s_tx      = s_shx[ACC_W-1:0];
    assign s_tc      = s_shc[ACC_W-1:0];
    assign s_part_lo = ENERGY_BITS'(s_prod[PROD_W-1:WEIGHT_FRAC]);
    assign s_part_hi = ENERGY_BITS'({s_prod, {HI_SHIFT{1'b0}}});

    // Select the operands of the shared multiplier for this step
    always_comb begin
        s_mul_a = '0;
        s_mul_b = '0;
        unique case (r_state)
            ST_B0: begin
                s_mul_a = MUL_W'(r_shelf_b0);
                s_mul_b = MUL_W'(r_frame[r_ch]);
            end
            ST_B1: begin
                s_mul_a = MUL_W'(r_shelf_b1);
                s_mul_b = MUL_W'(r_xh1[r_ch]);
            end
            ST_B2: begin
                s_mul_a = MUL_W'(r_shelf_b2);
                s_mul_b = MUL_W'(r_xh2[r_ch]);
            end
            ST_SA1: begin
                s_mul_a = MUL_W'(r_shelf_a1);
                s_mul_b = MUL_W'(r_yh1[r_ch]);
            end
            ST_SA2: begin
                s_mul_a = MUL_W'(r_shelf_a2);
                s_mul_b = MUL_W'(r_yh2[r_ch]);
            end
            ST_HA1: begin
                s_mul_a = MUL_W'(r_highpass_a1);
                s_mul_b = MUL_W'(r_zh1[r_ch]);
            end
            ST_HA2: begin
                s_mul_a = MUL_W'(r_highpass_a2);
                s_mul_b = MUL_W'(r_zh2[r_ch]);
            end
            ST_SQ: begin
                s_mul_a = MUL_W'(r_z);
                s_mul_b = MUL_W'(r_z);
            end
            ST_WLO: begin
                s_mul_a[LO_BITS-1:0]     = s_prod[HI_LSB-1:SQ_SHIFT];
                s_mul_b[WEIGHT_BITS-1:0] = s_weight;
            end
            ST_WHI: begin
                s_mul_a[HI_BITS-1:0]     = r_hi;
                s_mul_b[WEIGHT_BITS-1:0] = s_weight;
            end
            default: begin
                s_mul_a = '0;
                s_mul_b = '0;
            end
        endcase
    end

    kwef_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (s_mul_a),
        .i_b    (s_mul_b),
        .o_prod (s_prod)
    );

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CH_COUNT_RESET;
            r_shelf_b0      <= 32'sd412081942;
            r_shelf_b1      <= -32'sd722546694;
            r_shelf_b2      <= 32'sd321691121;
            r_shelf_a1      <= -32'sd453832898;
            r_shelf_a2      <= 32'sd196623811;
            r_highpass_a1   <= -32'sd534199296;
            r_highpass_a2   <= 32'sd265770496;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                CFG_SHELF_B0:      r_shelf_b0      <= i_cfg_data;
                CFG_SHELF_B1:      r_shelf_b1      <= i_cfg_data;
                CFG_SHELF_B2:      r_shelf_b2      <= i_cfg_data;
                CFG_SHELF_A1:      r_shelf_a1      <= i_cfg_data;
                CFG_SHELF_A2:      r_shelf_a2      <= i_cfg_data;
                CFG_HIGHPASS_A1:   r_highpass_a1   <= i_cfg_data;
                CFG_HIGHPASS_A2:   r_highpass_a2   <= i_cfg_data;
            endcase
        end
    end

    // Sequence the steps of each channel and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_primed <= 1'b0;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != ST_FINISH)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (!r_primed) begin
                            if (!i_flush) begin
                                r_primed <= 1'b1;
                                r_state  <= ST_FINISH;
                            end
                        end else begin
                            r_ch    <= '0;
                            r_state <= (s_n == '0) ? ST_FINISH : ST_B0;
                        end
                    end
                end
                ST_B0:     r_state <= ST_B1;
                ST_B1:     r_state <= ST_B2;
                ST_B2:     r_state <= ST_SA1;
                ST_SA1:    r_state <= ST_SA2;
                ST_SA2:    r_state <= ST_HA1;
                ST_HA1:    r_state <= ST_HA2;
                ST_HA2:    r_state <= ST_LIN;
                ST_LIN:    r_state <= ST_ZCLAMP;
                ST_ZCLAMP: r_state <= ST_SQ;
                ST_SQ:     r_state <= ST_WLO;
                ST_WLO:    r_state <= ST_WHI;
                ST_WHI:    r_state <= ST_EHI;
                ST_EHI: begin
                    if (s_last) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_ch    <= r_ch + IDX_W'(1);
                        r_state <= ST_B0;
                    end
                end
                ST_FINISH: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid  <= 1'b1;
                        r_oenergy <= r_energy;
                        r_state   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Advance the channel histories on priming and at the end of each channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_xh1[i] <= '0;
                r_xh2[i] <= '0;
                r_yh1[i] <= '0;
                r_yh2[i] <= '0;
                r_zh1[i] <= '0;
                r_zh2[i] <= '0;
            end
        end else if (s_accept && !r_primed && !i_flush) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                if (CNT_W'(i) < s_n) begin
                    r_xh1[i] <= s_sample[i];
                    r_xh2[i] <= r_xh1[i];
                end
            end
        end else if (r_state == ST_EHI) begin
            r_xh1[r_ch] <= r_frame[r_ch];
            r_xh2[r_ch] <= r_xh1[r_ch];
            r_yh1[r_ch] <= r_y;
            r_yh2[r_ch] <= r_yh1[r_ch];
            r_zh1[r_ch] <= r_z;
            r_zh2[r_ch] <= r_zh1[r_ch];
        end
    end

    // Accumulate filter terms and the weighted energy
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    r_energy <= '0;
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        r_frame[i] <= i_flush ? '0 : s_sample[i];
                    end
                end
            end
            ST_B1:  r_acc <= s_tx;
            ST_B2:  r_acc <= r_acc + s_tx;
            ST_SA1: r_acc <= r_acc + s_tx;
            ST_SA2: r_acc <= r_acc - s_tc;
            ST_HA1: r_acc <= r_acc - s_tc;
            ST_HA2: begin
                r_y   <= clamp(r_acc);
                r_acc <= -s_tc;
            end
            ST_LIN: begin
                r_acc <= r_acc - s_tc;
                r_lin <= LIN_W'(r_y) + LIN_W'(r_yh2[r_ch]) - (LIN_W'(r_yh1[r_ch]) <<< 1);
            end
            ST_ZCLAMP: r_z      <= clamp(r_acc + ACC_W'(r_lin));
            ST_WLO:    r_hi     <= s_prod[HI_LSB+HI_BITS-1:HI_LSB];
            ST_WHI:    r_energy <= sat_add(r_energy, s_part_lo);
            ST_EHI:    r_energy <= sat_add(r_energy, s_part_hi);
            default: begin
            end
        endcase
    end

endmodule
